>>> design/alsp_pkg.sv
// ----------------------------------------------------------------------------
// APT line-sync pixel formatter package
// Shared constants, sync patterns, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package alsp_pkg;

  localparam int WINDOW_LEN_DEF     = 40;
  localparam int MAX_LINE_WIDTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int LINE_WIDTH_BITS = 13;
  localparam int FRAME_BITS      = 16;
  localparam int THRESH_BITS     = 6;
  localparam int COLUMN_BITS     = 12;
  localparam int PIXEL_BITS      = 8;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int MIN_LINE_WIDTH  = 80;
  localparam int FILL_MAX        = 39;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_LINES = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_ENABLE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD   = 2'd3;

  // Sync patterns, bit i is window position i (0 = oldest)
  localparam logic [39:0] PAT_A = {
    4'b0000, 4'b0000, 4'b0011, 4'b0011, 4'b0011,
    4'b0011, 4'b0011, 4'b0011, 4'b0011, 4'b0000};
  localparam logic [39:0] PAT_B = {
    1'b0, 5'b00111, 5'b00111, 5'b00111, 5'b00111,
    5'b00111, 5'b00111, 5'b00111, 4'b0000};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_CORR,
    ST_DECIDE,
    ST_FILL_RD,
    ST_FILL_DIV,
    ST_FILL_OUT,
    ST_CUR_DIV,
    ST_CUR_OUT
  } state_t;

endpackage

>>> design/alsp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module alsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/apt_line_sync_pixel_formatter.sv
// ----------------------------------------------------------------------------
// APT line-sync pixel formatter
// Places demodulated APT samples as grey pixels in a line/frame raster with
// sync-pattern line realignment.
// ----------------------------------------------------------------------------
// Usage: samples arrive on sample/in_valid/in_stall; results leave on
// column/row/pixel/is_fill/frame_end/last with out_valid/out_stall. Each
// sample yields 1 to 40 results, the last flagged by last. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// The 40-entry history is a circular buffer in a RAM. Per sample: one write,
// the correlation (one entry per cycle, one RAM port, registered read),
// then per result one read and a serial divide for the range scaling plus
// an output step. Input is taken only between samples.
// After reset a clearing pass writes zero to all 40 history entries
// before the first sample is taken. When out_stall is high the
// current result holds and the sequencer waits.
// ----------------------------------------------------------------------------
module apt_line_sync_pixel_formatter #(
  parameter int WINDOW_LEN     = alsp_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS    = alsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [alsp_pkg::COLUMN_BITS-1:0] column,
  output logic [alsp_pkg::FRAME_BITS-1:0]  row,
  output logic [alsp_pkg::PIXEL_BITS-1:0]  pixel,
  output logic                          is_fill,
  output logic                          frame_end,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [alsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [alsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import alsp_pkg::*;

  localparam int AW    = $clog2(WINDOW_LEN);
  localparam int AVGW  = SAMPLE_BITS + 2;
  localparam int CNTW  = $clog2(WINDOW_LEN + 1);
  localparam int DIVCW = $clog2(SAMPLE_BITS + 1);
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;
  localparam logic [LINE_WIDTH_BITS-1:0] WMAX = LINE_WIDTH_BITS'(MAX_LINE_WIDTH_DEF);
  localparam logic [LINE_WIDTH_BITS-1:0] WMIN = LINE_WIDTH_BITS'(MIN_LINE_WIDTH);
  localparam logic [AW-1:0] LASTA = AW'(WINDOW_LEN - 1);

  // Configuration registers
  logic [LINE_WIDTH_BITS-1:0] line_width;
  logic [FRAME_BITS-1:0]      frame_lines;
  logic                       sync_enable;
  logic [THRESH_BITS-1:0]     match_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width      <= LINE_WIDTH_BITS'(2080);
      frame_lines     <= FRAME_BITS'(1800);
      sync_enable     <= 1'b1;
      match_threshold <= THRESH_BITS'(35);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_WIDTH:  line_width      <= cfg_data[LINE_WIDTH_BITS-1:0];
        REG_FRAME_LINES: frame_lines     <= cfg_data[FRAME_BITS-1:0];
        REG_SYNC_ENABLE: sync_enable     <= cfg_data[0];
        REG_THRESHOLD:   match_threshold <= cfg_data[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and pattern B column
  logic [LINE_WIDTH_BITS-1:0] eff_w;
  always_comb begin
    eff_w = line_width;
    if (eff_w < WMIN) eff_w = WMIN;
    if (eff_w > WMAX) eff_w = WMAX;
  end

  // State registers
  state_t state, state_next;
  logic [AW-1:0]          head;      // slot of the oldest entry
  logic [AW-1:0]          idx;       // walk counter
  logic [AW:0]            fill_n;    // fill count
  logic [AW:0]            fill_i;
  logic [SAMPLE_BITS-1:0] cur_s;
  logic [AVGW-1:0]        avg;
  logic [SAMPLE_BITS-1:0] lmin, lmax;
  logic                   seen;
  logic [COLUMN_BITS-1:0] col_pos;
  logic [FRAME_BITS-1:0]  row_pos;
  logic [CNTW-1:0]        ca, cb;
  logic [LINE_WIDTH_BITS:0] target;
  logic                   rd_valid;
  logic [AW-1:0]          rd_pos;

  // RAM
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;

  alsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_LEN)) u_hist (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW:0] b);
    logic [AW+1:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= (AW+2)'(WINDOW_LEN)) t = t - (AW+2)'(WINDOW_LEN);
    return t[AW-1:0];
  endfunction

  // Serial divider: (s-min)*255 / (max-min)
  logic [SAMPLE_BITS+8-1:0] dnum;
  logic [SAMPLE_BITS-1:0]   dden;
  logic [SAMPLE_BITS:0]     drem;
  logic [SAMPLE_BITS+8-1:0] dquo;
  logic [DIVCW+1:0]         dcnt;
  logic [SAMPLE_BITS-1:0]   dsrc;
  logic                     dzero, dsat;
  logic [SAMPLE_BITS:0]     rem_sh;

  assign rem_sh = {drem[SAMPLE_BITS-1:0], dnum[SAMPLE_BITS+8-1]};

  // Output register
  logic [COLUMN_BITS-1:0] o_col;
  logic [FRAME_BITS-1:0]  o_row;
  logic                   o_fill, o_fend, o_last;

  assign column    = o_col;
  assign row       = o_row;
  assign is_fill   = o_fill;
  assign frame_end = o_fend;
  assign last      = o_last;
  assign in_stall  = (state != ST_IDLE);

  logic [SAMPLE_BITS+7:0] quo_cap;
  assign quo_cap = dquo;

  // Next state
  logic corr_done, div_done;
  assign corr_done = (rd_pos == LASTA) && rd_valid;
  assign div_done  = (dcnt == (DIVCW+2)'(SAMPLE_BITS + 8));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (idx == LASTA) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_SHIFT;
      ST_SHIFT:    state_next = sync_enable ? ST_CORR : ST_CUR_DIV;
      ST_CORR:     if (corr_done) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = ST_FILL_RD;
      ST_FILL_RD:  state_next = (fill_i == fill_n) ? ST_CUR_DIV : ST_FILL_DIV;
      ST_FILL_DIV: if (div_done) state_next = ST_FILL_OUT;
      ST_FILL_OUT: if (!out_stall) state_next = ST_FILL_RD;
      ST_CUR_DIV:  if (div_done) state_next = ST_CUR_OUT;
      ST_CUR_OUT:  if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer toward the RAM and the result channel
  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = cur_s;
    raddr = wrap_add(head, {1'b0, idx});
    out_valid = (state == ST_FILL_OUT) || (state == ST_CUR_OUT);
    case (state)
      ST_CLEAR: begin
        we = 1'b1; waddr = idx; wdata = '0;
      end
      ST_IDLE: begin
        we = in_valid; waddr = head; wdata = sample;
      end
      ST_FILL_RD: begin
        // entry 39 - n + i in window order
        raddr = wrap_add(head, (AW+1)'(WINDOW_LEN - 1) - fill_n + fill_i);
      end
      default: ;
    endcase
  end

  // Pixel with degenerate cases
  always_comb begin
    if (dzero) pixel = '0;
    else if (dsat) pixel = 8'd255;
    else pixel = quo_cap[PIXEL_BITS-1:0];
  end

  logic hit_a, hit_b;
  logic [CNTW:0] thr;
  assign thr = (CNTW+1)'(match_threshold);
  logic [LINE_WIDTH_BITS:0] tgt_b;
  assign tgt_b = {2'b0, eff_w[LINE_WIDTH_BITS-1:1]} + (LINE_WIDTH_BITS+1)'(39);
  // Sync decision straight from the finished counts
  logic hit_a_now, hit_b_now;
  logic [LINE_WIDTH_BITS:0] target_now;
  assign hit_a_now  = ((CNTW+1)'(ca) > thr);
  assign hit_b_now  = !hit_a_now && ((CNTW+1)'(cb) > thr);
  assign target_now = hit_a_now ? (LINE_WIDTH_BITS+1)'(39) : tgt_b;
  logic [AVGW+1:0] avg3;
  assign avg3 = {1'b0, avg, 1'b0} + {2'b0, avg};
  logic [AVGW-1:0] q;
  assign q = {rdata, 2'b00};
  logic [COLUMN_BITS:0] col_inc;
  assign col_inc = {1'b0, col_pos} + 1'b1;

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      head    <= '0;
      avg     <= '0;
      lmin    <= SMAX;
      lmax    <= '0;
      seen    <= 1'b0;
      col_pos <= '0;
      row_pos <= '0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: idx <= idx + 1'b1;
        ST_IDLE: if (in_valid) begin
          cur_s <= sample;
          if (sample > lmax) lmax <= sample;
          if (sample < lmin) lmin <= sample;
          avg   <= AVGW'({2'b0, sample}) + avg3[AVGW+1:2];
          head  <= (head == LASTA) ? '0 : head + 1'b1;
          idx   <= '0;
          ca    <= '0;
          cb    <= '0;
          rd_valid <= 1'b0;
          fill_n <= '0;
          fill_i <= '0;
          dsrc  <= sample;
          dcnt  <= '0;
        end
        ST_SHIFT: begin
          idx <= '0;
          rd_valid <= 1'b0;
          dcnt <= '0;
        end
        ST_CORR: begin
          // pipeline: address idx issued this cycle, data for rd_pos arrives
          if (!rd_valid) begin
            rd_valid <= 1'b1;
            rd_pos <= idx;
            idx <= idx + 1'b1;
          end else begin
            if ((q > avg && PAT_A[rd_pos]) || (q < avg && !PAT_A[rd_pos])) ca <= ca + 1'b1;
            if ((q > avg && PAT_B[rd_pos]) || (q < avg && !PAT_B[rd_pos])) cb <= cb + 1'b1;
            rd_pos <= idx;
            if (idx != LASTA) idx <= idx + 1'b1;
          end
        end
        ST_DECIDE: begin
          fill_i <= '0;
          if (hit_a_now || hit_b_now) begin
            if (target_now > (LINE_WIDTH_BITS+1)'(col_pos)) begin
              if (target_now - (LINE_WIDTH_BITS+1)'(col_pos) > (LINE_WIDTH_BITS+1)'(FILL_MAX))
                fill_n <= (AW+1)'(FILL_MAX);
              else
                fill_n <= (AW+1)'(target_now - (LINE_WIDTH_BITS+1)'(col_pos));
            end else begin
              fill_n <= '0;
            end
          end else begin
            fill_n <= '0;
          end
        end
        ST_FILL_RD: begin
          dcnt <= '0;
          if (fill_i == fill_n) begin
            // fill done: apply jump and first-sync level reset
            if (hit_a || hit_b) begin
              col_pos <= target[COLUMN_BITS-1:0];
              if (!seen) begin
                lmin <= SMAX; lmax <= '0; seen <= 1'b1;
              end
            end
            dsrc <= cur_s;
          end
        end
        ST_FILL_DIV, ST_CUR_DIV: begin
          dcnt <= dcnt + 1'b1;
        end
        ST_FILL_OUT: if (!out_stall) fill_i <= fill_i + 1'b1;
        ST_CUR_OUT: if (!out_stall) begin
          if (col_inc >= (COLUMN_BITS+1)'(eff_w)) begin
            col_pos <= '0;
            if ({1'b0, row_pos} + 1'b1 >= (FRAME_BITS+1)'(frame_lines)) row_pos <= '0;
            else row_pos <= row_pos + 1'b1;
          end else begin
            col_pos <= col_inc[COLUMN_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Sync decision, held over the fill walk
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      hit_a <= 1'b0; hit_b <= 1'b0;
    end else if (state == ST_DECIDE) begin
      hit_a  <= hit_a_now;
      hit_b  <= hit_b_now;
      target <= target_now;
    end
  end

  // Divider source: history entry for a fill pixel, else the current sample
  logic [SAMPLE_BITS-1:0] div_src;
  assign div_src = (state == ST_FILL_DIV) ? rdata : dsrc;

  // Divider: one quotient bit per cycle; first cycle loads operands
  always_ff @(posedge clk) begin
    if (state == ST_FILL_DIV || state == ST_CUR_DIV) begin
      if (dcnt == '0) begin
        dzero <= (lmax <= lmin) || (div_src <= lmin);
        dsat  <= (div_src >= lmax);
        dnum  <= ({8'b0, div_src - lmin} << 8) - {8'b0, div_src - lmin};
        dden <= lmax - lmin;
        drem <= '0;
        dquo <= '0;
      end else begin
        if (rem_sh >= {1'b0, dden}) begin
          drem <= rem_sh - {1'b0, dden};
          dquo <= {dquo[SAMPLE_BITS+6:0], 1'b1};
        end else begin
          drem <= rem_sh;
          dquo <= {dquo[SAMPLE_BITS+6:0], 1'b0};
        end
        dnum <= {dnum[SAMPLE_BITS+6:0], 1'b0};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_FILL_DIV) begin
      o_col  <= COLUMN_BITS'(target - (LINE_WIDTH_BITS+1)'(fill_n) + (LINE_WIDTH_BITS+1)'(fill_i));
      o_row  <= row_pos;
      o_fill <= 1'b1; o_fend <= 1'b0; o_last <= 1'b0;
    end else if (state == ST_CUR_DIV) begin
      o_col  <= col_pos;
      o_row  <= row_pos;
      o_fill <= 1'b0; o_last <= 1'b1;
      o_fend <= (col_inc >= (COLUMN_BITS+1)'(eff_w)) &&
                ({1'b0, row_pos} + 1'b1 >= (FRAME_BITS+1)'(frame_lines));
    end
  end

endmodule
